### hw/rtl/suk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suk_pkg
// Shared types and codes of the sorted unique key set: request and status
// codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package suk_pkg;

    localparam logic [1:0] FN_INSERT   = 2'd0;
    localparam logic [1:0] FN_DELETE   = 2'd1;
    localparam logic [1:0] FN_TRAVERSE = 2'd2;
    localparam logic [1:0] FN_RESERVED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_LISTED    = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic next;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic no_result;
    } t_stat;

endpackage
`default_nettype wire

### hw/rtl/suk_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suk_datapath
// Sorted cell chain with per-cell compare, registered shift on insert and
// delete, traverse index and the output word register.
// ----------------------------------------------------------------------------
module suk_datapath #(
    parameter int CAPACITY = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_func,
    input  wire logic [15:0]   i_key,
    input  wire suk_pkg::t_cmd i_cmd,
    output suk_pkg::t_stat     o_stat,
    output logic [2:0]         o_status,
    output logic [15:0]        o_key_out,
    output logic [6:0]         o_entry_count,
    output logic               o_last
);
    import suk_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [1:0]    r_func;
    logic [15:0]   r_key;
    logic [15:0]   r_keys [CAPACITY];
    logic [15:0]   n_keys [CAPACITY];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] rd_idx;
    logic [15:0]   rd_key;
    logic          trav_last;

    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic dup;
    logic full;
    logic do_ins;
    logic do_del;

    logic [2:0]  r_status;
    logic [15:0] r_key_out;
    logic [6:0]  r_out_count;
    logic        r_last;

    // per-cell compare and shift source
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic        used;
        logic [15:0] ins_val;
        logic [15:0] del_val;
        assign used  = r_count > CW'(g);
        assign lt[g] = used && (r_keys[g] < r_key);
        assign eq[g] = used && (r_keys[g] == r_key);
        if (g == 0) begin : g_first
            assign ins_val = r_key;
        end else begin : g_rest
            assign ins_val = lt[g-1] ? r_key : r_keys[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign del_val = r_keys[g];
        end else begin : g_mid
            assign del_val = r_keys[g+1];
        end
        assign n_keys[g] = lt[g] ? r_keys[g] : (do_ins ? ins_val : del_val);
    end

    assign dup    = |eq;
    assign full   = r_count == CW'(CAPACITY);
    assign do_ins = i_cmd.exec && (r_func == FN_INSERT) && !dup && !full;
    assign do_del = i_cmd.exec && (r_func == FN_DELETE) && dup;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_del) begin
            n_count = r_count - 1'b1;
        end
    end

    assign rd_idx    = i_cmd.exec ? '0 : r_idx + 1'b1;
    assign rd_key    = r_keys[rd_idx];
    assign trav_last = ((CW+1)'(rd_idx) + 1'b1) == (CW+1)'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= i_key;
        end
        if (do_ins || do_del) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_keys[i] <= n_keys[i];
            end
        end
        if (i_cmd.exec || i_cmd.next) begin
            r_idx <= rd_idx;
        end
        if (i_cmd.exec) begin
            r_out_count <= 7'(n_count);
            case (r_func)
                FN_INSERT: begin
                    r_status  <= dup ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
                    r_key_out <= r_key;
                    r_last    <= 1'b1;
                end
                FN_DELETE: begin
                    r_status  <= dup ? ST_REMOVED : ST_NOT_FOUND;
                    r_key_out <= r_key;
                    r_last    <= 1'b1;
                end
                FN_TRAVERSE: begin
                    if (r_count == '0) begin
                        r_status  <= ST_EMPTY;
                        r_key_out <= '0;
                        r_last    <= 1'b1;
                    end else begin
                        r_status  <= ST_LISTED;
                        r_key_out <= rd_key;
                        r_last    <= trav_last;
                    end
                end
                default: begin
                    r_status <= r_status;
                end
            endcase
        end else if (i_cmd.next) begin
            r_status  <= ST_LISTED;
            r_key_out <= rd_key;
            r_last    <= trav_last;
        end
    end

    assign o_stat.last      = r_last;
    assign o_stat.no_result = r_func == FN_RESERVED;
    assign o_status         = r_status;
    assign o_key_out        = r_key_out;
    assign o_entry_count    = r_out_count;
    assign o_last           = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("insert did not grow the set");

    for (genvar g = 0; g < CAPACITY - 1; g++) begin : g_order
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_count > CW'(g + 1)) |-> (r_keys[g] < r_keys[g+1]))
            else $error("cell chain out of order");
    end

endmodule
`default_nettype wire

### hw/rtl/suk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suk_ctrl
// Controller of the sorted unique key set: takes a request, executes it,
// then holds the output word until every result is taken, if it has any.
// ----------------------------------------------------------------------------
module suk_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_ready,
    input  wire suk_pkg::t_stat i_stat,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output suk_pkg::t_cmd       o_cmd
);
    import suk_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   done;

    assign done   = (r_state == S_OUT) && i_out_ready && i_stat.last;
    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.no_result ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                if (done) n_state = i_in_valid ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready && i_stat.last;
                o_cmd.next  = i_out_ready && !i_stat.last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load = accept;
    end

endmodule
`default_nettype wire

### hw/rtl/sorted_unique_key_set.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_key_set
// Set of distinct 16-bit keys held in ascending order with insert, delete
// and traverse requests.
// ----------------------------------------------------------------------------
// Keys live in a chain of CAPACITY sorted cells, each with its own compare,
// so an insert or delete finds its place and shifts the chain in the
// execute step, then holds the result word on the output until it is taken.
// A traverse runs the execute step and then gives one stored key per cycle
// while the result taker is ready, the last one marked; an empty set gives
// a single empty word. Reserved request code 3 is taken and dropped with no
// result. A new request is taken only once the last result word of the one
// before is taken. The rate is set by the execute state of the controller
// followed by the output register. No clearing is needed after reset.
// ----------------------------------------------------------------------------
module sorted_unique_key_set #(
    parameter int CAPACITY = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_key,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_key_out,
    output logic [6:0]       o_entry_count,
    output logic             o_last
);
    import suk_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    suk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    suk_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_key         (i_key),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_key_out     (o_key_out),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

### sim/sorted_unique_key_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_key_set_checker
// Watches both channels of the sorted key set and keeps its own copy of the
// set. It predicts the result words of every accepted request and compares
// each accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_unique_key_set_checker #(
    parameter int CAPACITY = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_key,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  i_status,
    input  wire logic [15:0] i_key_out,
    input  wire logic [6:0]  i_entry_count,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending,
    output int               o_words,
    output int               o_full_reports
);
    import suk_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] key;
        logic [6:0]  count;
        logic        last;
    } t_sk_word;

    logic [15:0] set_keys [CAPACITY];
    int          set_size = 0;
    t_sk_word    want_q [$];
    int          err_total = 0;
    int          word_total = 0;
    int          full_total = 0;

    task automatic predict_request(input logic [1:0] fn, input logic [15:0] k);
        int       slot;
        int       i;
        bit       hit;
        t_sk_word w;
        slot = 0;
        while (slot < set_size && set_keys[slot] < k)
            slot++;
        hit = (slot < set_size) && (set_keys[slot] == k);
        w.key  = k;
        w.last = 1'b1;
        case (fn)
            FN_INSERT: begin
                if (hit) begin
                    w.status = ST_DUPLICATE;
                end else if (set_size >= CAPACITY) begin
                    w.status = ST_FULL;
                    full_total++;
                end else begin
                    for (i = set_size; i > slot; i--)
                        set_keys[i] = set_keys[i - 1];
                    set_keys[slot] = k;
                    set_size++;
                    w.status = ST_INSERTED;
                end
                w.count = 7'(set_size);
                want_q.push_back(w);
            end
            FN_DELETE: begin
                if (hit) begin
                    for (i = slot; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i + 1];
                    set_size--;
                    w.status = ST_REMOVED;
                end else begin
                    w.status = ST_NOT_FOUND;
                end
                w.count = 7'(set_size);
                want_q.push_back(w);
            end
            FN_TRAVERSE: begin
                if (set_size == 0) begin
                    w.status = ST_EMPTY;
                    w.key    = 16'h0000;
                    w.count  = 7'd0;
                    want_q.push_back(w);
                end else begin
                    for (i = 0; i < set_size; i++) begin
                        w.status = ST_LISTED;
                        w.key    = set_keys[i];
                        w.count  = 7'(set_size);
                        w.last   = (i + 1 == set_size);
                        want_q.push_back(w);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_sk_word got;
        t_sk_word want;
        if (!i_rst_n) begin
            set_size = 0;
            want_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_request(i_func, i_key);
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_key_out, i_entry_count, i_last};
                word_total++;
                if (want_q.size() == 0) begin
                    err_total++;
                    if (err_total <= 50)
                        $display("%0t: unexpected word: status %0d key %h count %0d last %0d",
                                 $time, got.status, got.key, got.count, got.last);
                end else begin
                    want = want_q.pop_front();
                    if (got !== want) begin
                        err_total++;
                        if (err_total <= 50)
                            $display({"%0t: word mismatch: expected status %0d key %h count %0d ",
                                      "last %0d, got status %0d key %h count %0d last %0d"},
                                     $time, want.status, want.key, want.count, want.last,
                                     got.status, got.key, got.count, got.last);
                    end
                end
            end
        end
        o_pending      <= want_q.size();
        o_errors       <= err_total;
        o_words        <= word_total;
        o_full_reports <= full_total;
    end

endmodule

### sim/sorted_unique_key_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_key_set_tb
// Drives insert, delete, traverse and reserved requests into the sorted key
// set: a directed opening over the key extremes and empty set cases, then
// random phases that fill, churn, drain and list the set, with bursty
// requests, a stalling result taker and a checker that scores every word.
// ----------------------------------------------------------------------------
module sorted_unique_key_set_tb;
    import suk_pkg::*;

    localparam int CAP        = 32;
    localparam int RAND_ITEMS = 500;
    localparam int HOLD_START = 800;
    localparam int HOLD_LEN   = 400;

    typedef enum {PH_FILL, PH_CHURN, PH_DRAIN, PH_LIST} t_phase;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FN_INSERT;
    logic [15:0] key = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] key_out;
    logic [6:0]  entry_count;
    logic        last;

    int errors;
    int pending;
    int words;
    int full_reports;

    logic [15:0] key_pool [$];
    int          sent = 0;
    int          burst_left = 0;
    int          rx_cycle = 0;

    sorted_unique_key_set #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (func),
        .i_key        (key),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (status),
        .o_key_out    (key_out),
        .o_entry_count(entry_count),
        .o_last       (last)
    );

    sorted_unique_key_set_checker #(
        .CAPACITY(CAP)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_func        (func),
        .i_key         (key),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_key_out     (key_out),
        .i_entry_count (entry_count),
        .i_last        (last),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_words       (words),
        .o_full_reports(full_reports)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("sorted_unique_key_set_tb: done, errors");
        $finish;
    end

    // result taker: changing stall pattern, one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_cycle  <= 0;
            out_ready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
                out_ready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(3) != 0);
                    2: out_ready <= 1'($urandom_range(1));
                    default: out_ready <= ($urandom_range(4) == 0);
                endcase
            end
        end
    end

    function automatic logic [15:0] pick_key(int fresh_pct);
        int r;
        r = $urandom_range(99);
        if (key_pool.size() == 0 || r < fresh_pct) begin
            case ($urandom_range(7))
                0: return 16'h0000;
                1: return 16'hFFFF;
                default: return 16'($urandom);
            endcase
        end
        r = $urandom_range(key_pool.size() - 1);
        case ($urandom_range(5))
            0: return key_pool[r] + 16'd1;
            1: return key_pool[r] - 16'd1;
            default: return key_pool[r];
        endcase
    endfunction

    task automatic send_word(input logic [1:0] f, input logic [15:0] k);
        in_valid <= 1'b1;
        func     <= f;
        key      <= k;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (f == FN_INSERT) begin
            key_pool.push_back(k);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
    endtask

    task automatic offer(input logic [1:0] f, input logic [15:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(10, 1);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        send_word(f, k);
        burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        t_phase      ph;
        int          ph_len;
        int          r;
        int          w_ins, w_del, w_trav, fresh;
        logic [1:0]  f;
        logic [15:0] k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, key extremes, duplicates, misses, reserved code
        offer(FN_TRAVERSE, 16'h5A5A);
        offer(FN_DELETE,   16'h1234);
        offer(FN_INSERT,   16'h8000);
        offer(FN_INSERT,   16'h0000);
        offer(FN_INSERT,   16'hFFFF);
        offer(FN_INSERT,   16'h8000);
        offer(FN_INSERT,   16'h7FFF);
        offer(FN_INSERT,   16'h8001);
        offer(FN_TRAVERSE, 16'hFFFF);
        offer(FN_DELETE,   16'hFFFF);
        offer(FN_DELETE,   16'h0001);
        offer(FN_DELETE,   16'h0000);
        offer(FN_RESERVED, 16'hFFFF);
        offer(FN_RESERVED, 16'h0000);
        offer(FN_TRAVERSE, 16'h0000);
        offer(FN_DELETE,   16'h8000);
        offer(FN_DELETE,   16'h7FFF);
        offer(FN_DELETE,   16'h8001);
        offer(FN_TRAVERSE, 16'hA5A5);
        wait_idle();

        ph = PH_FILL;
        while (sent < 19 + RAND_ITEMS) begin
            case (ph)
                PH_FILL:  begin w_ins = 80; w_del = 8;  w_trav = 8;  fresh = 85; end
                PH_CHURN: begin w_ins = 40; w_del = 40; w_trav = 15; fresh = 40; end
                PH_DRAIN: begin w_ins = 10; w_del = 75; w_trav = 12; fresh = 20; end
                default:  begin w_ins = 30; w_del = 25; w_trav = 42; fresh = 50; end
            endcase
            ph_len = (ph == PH_FILL) ? $urandom_range(90, 60) : $urandom_range(80, 30);
            repeat (ph_len) begin
                r = $urandom_range(99);
                if (r < w_ins) begin
                    f = FN_INSERT;
                    k = pick_key(fresh);
                end else if (r < w_ins + w_del) begin
                    f = FN_DELETE;
                    k = pick_key(15);
                end else if (r < w_ins + w_del + w_trav) begin
                    f = FN_TRAVERSE;
                    k = 16'($urandom);
                end else begin
                    f = FN_RESERVED;
                    k = 16'($urandom);
                end
                offer(f, k);
            end
            wait_idle();
            ph = t_phase'($urandom_range(3));
        end

        in_valid <= 1'b0;
        wait_idle();
        repeat (40) @(posedge clk);

        $display("covered %0d requests and %0d result words, %0d inserts refused as full",
                 sent, words, full_reports);
        if (errors == 0 && pending == 0)
            $display("sorted_unique_key_set_tb: done, clean");
        else
            $display("sorted_unique_key_set_tb: done, errors");
        $finish;
    end

endmodule
